[sv/sdd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdd_pkg
// Types, field widths and calendar tables shared by the date difference core.
// ----------------------------------------------------------------------------
package sdd_pkg;

	localparam int DAY_W    = 5;
	localparam int MONTH_W  = 4;
	localparam int YEAR_W   = 14;
	localparam int DIFF_W   = 23;
	// A day serial number of any 14-bit year fits in 23 bits.
	localparam int SERIAL_W = 23;
	localparam int PROD_W   = 25;

	// x / 25 == (x * 5243) >> 17 for every x below 4096.
	localparam logic [PROD_W-1:0] DIV25_MUL   = 25'd5243;
	localparam int                DIV25_SHIFT = 17;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	typedef struct packed {
		logic [DAY_W-1:0]   day_a;
		logic [MONTH_W-1:0] month_a;
		logic [YEAR_W-1:0]  year_a;
		logic [DAY_W-1:0]   day_b;
		logic [MONTH_W-1:0] month_b;
		logic [YEAR_W-1:0]  year_b;
		logic               include_end;
	} date_pair_t;

	typedef struct packed {
		logic signed [DIFF_W-1:0] day_difference;
		logic                     date_invalid;
	} diff_t;

	// Days in the months before the given one, common year.
	function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
		logic [8:0] r;
		case (m)
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// Length of a month in a common year.
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] r;
		case (m)
			4'd2:    r = 5'd28;
			4'd4:    r = 5'd30;
			4'd6:    r = 5'd30;
			4'd9:    r = 5'd30;
			4'd11:   r = 5'd30;
			default: r = 5'd31;
		endcase
		return r;
	endfunction

endpackage

[sv/signed_date_difference_core.sv]
`timescale 1ns / 1ps
// Path: an accepted item passes through stage registers s1, s2, s3 and s4.
// Throughput: one item per cycle; each stage holds only while the stage
// ahead of it is full and held, so bubbles are squeezed out under stall.
// Reset: arst_n clears the stage valid bits at once; data registers keep
// whatever they hold.
// ----------------------------------------------------------------------------
// signed_date_difference_core
// Signed day count between two Gregorian dates, with an invalid-date flag.
// ----------------------------------------------------------------------------
module signed_date_difference_core #(
	parameter int unsigned MAX_YEAR = 9999
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                dates_valid,
	output logic                dates_stall,
	input  sdd_pkg::date_pair_t dates,
	output logic                diff_valid,
	input  logic                diff_stall,
	output sdd_pkg::diff_t      diff
);
	import sdd_pkg::*;

	localparam int WIDE_W = SERIAL_W + 2;

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	assign en4 = !v_s4 || !diff_stall;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign dates_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= dates_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	logic [SERIAL_W-1:0] serial_a, serial_b;
	logic                ok_a, ok_b;

	sdd_serial #(.MAX_YEAR(MAX_YEAR)) u_serial_a (
		.clk      (clk),
		.stage_en ({en3, en2, en1}),
		.day      (dates.day_a),
		.month    (dates.month_a),
		.year     (dates.year_a),
		.serial   (serial_a),
		.date_ok  (ok_a)
	);

	sdd_serial #(.MAX_YEAR(MAX_YEAR)) u_serial_b (
		.clk      (clk),
		.stage_en ({en3, en2, en1}),
		.day      (dates.day_b),
		.month    (dates.month_b),
		.year     (dates.year_b),
		.serial   (serial_b),
		.date_ok  (ok_b)
	);

	logic inc_s1, inc_s2, inc_s3;

	always_ff @(posedge clk) begin
		if (en1) inc_s1 <= dates.include_end;
		if (en2) inc_s2 <= inc_s1;
		if (en3) inc_s3 <= inc_s2;
	end

	// When the first date is not earlier, sb - sa is zero or negative and
	// the end day moves the count one further from zero.
	logic signed [WIDE_W-1:0] delta_c;
	logic signed [WIDE_W-1:0] count_c;
	logic signed [WIDE_W-1:0] inc_c;
	diff_t                    out_s4;

	always_comb begin
		delta_c = $signed(WIDE_W'(serial_b)) - $signed(WIDE_W'(serial_a));
		inc_c   = $signed(WIDE_W'(inc_s3));
		count_c = (serial_a < serial_b) ? (delta_c + inc_c) : (delta_c - inc_c);
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			out_s4.date_invalid   <= !(ok_a && ok_b);
			out_s4.day_difference <= (ok_a && ok_b) ? count_c[DIFF_W-1:0] : '0;
		end
	end

	assign diff_valid = v_s4;
	assign diff       = out_s4;

endmodule

[sv/sdd_serial.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdd_serial
// Three-stage conversion of one date into a day serial number plus a check
// that the date is real. Stage enables come from the owner of the valid bits.
// ----------------------------------------------------------------------------
module sdd_serial #(
	parameter int unsigned MAX_YEAR = 9999
) (
	input  logic                          clk,
	input  logic [2:0]                    stage_en,
	input  logic [sdd_pkg::DAY_W-1:0]     day,
	input  logic [sdd_pkg::MONTH_W-1:0]   month,
	input  logic [sdd_pkg::YEAR_W-1:0]    year,
	output logic [sdd_pkg::SERIAL_W-1:0]  serial,
	output logic                          date_ok
);
	import sdd_pkg::*;

	localparam logic [YEAR_W+1:0] YEAR_LIMIT = (YEAR_W+2)'(MAX_YEAR);

	// Stage 1: products.
	logic [YEAR_W-1:0]   pm1_c;
	logic [DAY_W-1:0]    day_s1;
	logic [MONTH_W-1:0]  month_s1;
	logic [YEAR_W-1:0]   year_s1;
	logic [YEAR_W-1:0]   pm1_s1;
	logic [PROD_W-1:0]   prod_y_s1;
	logic [PROD_W-1:0]   prod_p_s1;
	logic [SERIAL_W-1:0] p365_s1;

	assign pm1_c = year - YEAR_W'(1);

	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			day_s1    <= day;
			month_s1  <= month;
			year_s1   <= year;
			pm1_s1    <= pm1_c;
			prod_y_s1 <= PROD_W'(year[YEAR_W-1:2]) * DIV25_MUL;
			prod_p_s1 <= PROD_W'(pm1_c[YEAR_W-1:2]) * DIV25_MUL;
			p365_s1   <= SERIAL_W'(pm1_c) * SERIAL_W'(365);
		end
	end

	// Stage 2: leap rule, validity and the whole-year part of the serial.
	logic [7:0]          y100_c;
	logic [7:0]          p100_c;
	logic                div4_c;
	logic                div100_c;
	logic                leap_c;
	logic [DAY_W-1:0]    dim_c;
	logic                ok_c;
	logic [SERIAL_W-1:0] base_c;

	logic [DAY_W-1:0]    day_s2;
	logic [MONTH_W-1:0]  month_s2;
	logic                leap_s2;
	logic                ok_s2;
	logic [SERIAL_W-1:0] base_s2;

	always_comb begin
		y100_c   = prod_y_s1[DIV25_SHIFT +: 8];
		p100_c   = prod_p_s1[DIV25_SHIFT +: 8];
		div4_c   = (year_s1[1:0] == 2'd0);
		div100_c = div4_c && ((15'(y100_c) * 15'd100) == 15'(year_s1));
		leap_c   = div4_c && (!div100_c || (y100_c[1:0] == 2'd0));
		if (month_s1 == MONTH_FEB) begin
			dim_c = leap_c ? 5'd29 : 5'd28;
		end else begin
			dim_c = month_len(month_s1);
		end
		ok_c = (month_s1 >= MONTH_JAN) && (month_s1 <= MONTH_DEC)
			&& (year_s1 != '0) && ((YEAR_W+2)'(year_s1) <= YEAR_LIMIT)
			&& (day_s1 != '0) && (day_s1 <= dim_c);
		base_c = p365_s1 + SERIAL_W'(pm1_s1[YEAR_W-1:2]) - SERIAL_W'(p100_c)
			+ SERIAL_W'(p100_c[7:2]);
	end

	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			day_s2   <= day_s1;
			month_s2 <= month_s1;
			leap_s2  <= leap_c;
			ok_s2    <= ok_c;
			base_s2  <= base_c;
		end
	end

	// Stage 3: add the position within the year.
	logic [SERIAL_W-1:0] serial_s3;
	logic                ok_s3;

	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			ok_s3     <= ok_s2;
			serial_s3 <= base_s2 + SERIAL_W'(days_before(month_s2))
				+ SERIAL_W'(leap_s2 && (month_s2 > MONTH_FEB)) + SERIAL_W'(day_s2);
		end
	end

	assign serial  = serial_s3;
	assign date_ok = ok_s3;

endmodule

[sv/sdd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdd_checker
// Port-level checks on the date difference core, bound to its top level.
// ----------------------------------------------------------------------------
module sdd_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                dates_valid,
	input logic                dates_stall,
	input logic                diff_valid,
	input logic                diff_stall,
	input sdd_pkg::diff_t      diff
);
	import sdd_pkg::*;

	// A held result keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		diff_valid && diff_stall |=> diff_valid && $stable(diff))
		else $error("held result changed");

	// The input can only be held back when the whole pipe is full and held.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		dates_stall |-> diff_valid && diff_stall)
		else $error("input stalled without a held result");

	// An invalid date always reports a zero count.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		diff_valid && diff.date_invalid |-> diff.day_difference == '0)
		else $error("invalid item with nonzero count");

	// With the output not stalled, an accepted item reaches the output as a valid result.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(dates_valid && !dates_stall) ##1 !diff_stall ##1 !diff_stall
		##1 !diff_stall |=> diff_valid)
		else $error("result missing after pipeline latency");

endmodule

bind signed_date_difference_core sdd_checker u_sdd_checker (.*);
